// ----- rtl/arr_pkg.sv -----
// Package for the address range resolver: item types, operation and status codes.
// No dependencies.
package arr_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] OP_CREATE_BUF = 3'd0;
    localparam logic [2:0] OP_CREATE_PLACED = 3'd1;
    localparam logic [2:0] OP_CREATE_HEAP = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_DESTROY = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_PLACED = 2'd1;
    localparam logic [1:0] KIND_HEAP = 2'd2;

    localparam logic [1:0] FOUND_NONE = 2'd0;
    localparam logic [1:0] FOUND_BUFFER = 2'd1;
    localparam logic [1:0] FOUND_HEAP = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] key;
        logic [31:0] heap_key;
        logic [63:0] address;
        logic [63:0] size;
        logic        is_buffer;
        logic        heap_denies_buffers;
        logic        raytracing;
    } arr_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  found_kind;
        logic [31:0] found_key;
        logic [63:0] offset;
    } arr_out_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      key;
        logic [63:0]      start;
        logic [63:0]      stop;
        logic [31:0]      owner;
        logic [CNT_W-1:0] layer;
        logic             rt;
    } arr_entry_t;

endpackage

// ----- rtl/arr_table.sv -----
// Slot table: one memory of entries with a registered read port, plus valid flags and a count memory.
// Depends on arr_pkg.
module arr_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [arr_pkg::IDX_W-1:0]       rd_idx,
    output arr_pkg::arr_entry_t             rd_entry,
    output logic                            rd_valid,
    input  logic                            wr_en,
    input  logic [arr_pkg::IDX_W-1:0]       wr_idx,
    input  arr_pkg::arr_entry_t             wr_entry,
    input  logic                            clr_en,
    input  logic [arr_pkg::IDX_W-1:0]       clr_idx,
    input  logic                            cnt_wr_en,
    input  logic [arr_pkg::IDX_W-1:0]       cnt_idx,
    input  logic [arr_pkg::CNT_W-1:0]       cnt_wdata,
    output logic [arr_pkg::CNT_W-1:0]       cnt_rdata
);
    arr_pkg::arr_entry_t mem [arr_pkg::TABLE_ENTRIES];
    logic [arr_pkg::CNT_W-1:0] cnt_mem [arr_pkg::TABLE_ENTRIES];
    logic [arr_pkg::TABLE_ENTRIES-1:0] valid_reg;
    logic [arr_pkg::TABLE_ENTRIES-1:0] valid_next;

    always_comb begin
        valid_next = valid_reg;
        if (clr_en) begin
            valid_next[clr_idx] = 1'b0;
        end
        if (wr_en) begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_valid <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            rd_valid <= valid_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        rd_entry <= mem[rd_idx];
        if (cnt_wr_en) begin
            cnt_mem[cnt_idx] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_idx];
    end
endmodule

// ----- rtl/address_range_object_resolver_core.sv -----
// Top level of the address range resolver: sequencer that scans the slot table.
// Depends on arr_pkg and arr_table.
//
//  channel | direction | ports                        | payload
//  input   | in        | s_valid, s_ready             | s_data (arr_in_t)
//  result  | out       | m_valid, m_ready             | m_data (arr_out_t)
//
// Each item takes one to four scans of the table at one slot a cycle through the single
// registered read port of the slot memory. A placed buffer adds a layer-count read in S_CNT
// and then a layer search in S_WRITE. Ignored items skip the scans and present their result
// on the cycle after acceptance.
// Reset is synchronous on aresetn and clears the valid flags at once.
// The input is not ready from acceptance until the result is taken by m_ready.
module address_range_object_resolver_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  arr_pkg::arr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output arr_pkg::arr_out_t m_data
);
    localparam int IW = arr_pkg::IDX_W;
    localparam int CW = arr_pkg::CNT_W;
    localparam logic [IW:0] LAST = (IW + 1)'(arr_pkg::TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CNT, S_WRITE, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        P_A, P_B, P_C, P_D
    } pass_t;

    state_t state_reg;
    pass_t pass_reg;
    arr_pkg::arr_in_t item_reg;
    logic [63:0] end_reg;
    logic [IW:0] ptr_reg;
    logic [IW-1:0] idx_q_reg;
    logic vld_q_reg;
    logic [1:0] status_reg;
    logic [1:0] fkind_reg;
    logic [31:0] fkey_reg;
    logic [63:0] off_reg;

    logic free_ok_reg;
    logic [IW-1:0] free_reg;
    logic h_ok_reg;
    logic [IW-1:0] h_reg;
    logic [31:0] hkey_reg;
    logic [63:0] hstart_reg;
    logic r_ok_reg;
    logic [IW-1:0] r_reg;
    logic [CW-1:0] rlayer_reg;
    logic [63:0] rend_reg;
    logic rrt_reg;
    logic [31:0] rkey_reg;
    logic [63:0] rstart_reg;
    logic hit_reg;
    logic [arr_pkg::TABLE_ENTRIES:0] used_reg;
    logic [CW-1:0] layer_reg;
    logic [CW-1:0] count_reg;

    logic [IW-1:0] rd_idx;
    arr_pkg::arr_entry_t e;
    logic ev;
    logic wr_en;
    logic [IW-1:0] wr_idx;
    arr_pkg::arr_entry_t wr_entry;
    logic clr_en;
    logic cnt_wr_en;
    logic [IW-1:0] cnt_idx;
    logic [CW-1:0] cnt_wdata;
    logic [CW-1:0] cnt_rdata;

    arr_table u_table (
        .aclk(aclk), .aresetn(aresetn),
        .rd_idx(rd_idx), .rd_entry(e), .rd_valid(ev),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_entry(wr_entry),
        .clr_en(clr_en), .clr_idx(idx_q_reg),
        .cnt_wr_en(cnt_wr_en), .cnt_idx(cnt_idx), .cnt_wdata(cnt_wdata),
        .cnt_rdata(cnt_rdata)
    );

    logic [64:0] sum;
    logic ovl;
    logic cov;
    logic is_plain, is_placed, is_heap;
    logic scan_done;

    assign sum = {1'b0, s_data.address} + {1'b0, s_data.size};
    assign rd_idx = ptr_reg[IW-1:0];
    assign is_plain = vld_q_reg && ev && e.kind == arr_pkg::KIND_PLAIN;
    assign is_placed = vld_q_reg && ev && e.kind == arr_pkg::KIND_PLACED;
    assign is_heap = vld_q_reg && ev && e.kind == arr_pkg::KIND_HEAP;
    assign ovl = e.stop > item_reg.address && e.start < end_reg;
    assign cov = item_reg.address >= e.start && item_reg.address < e.stop;
    assign scan_done = ptr_reg == LAST && !vld_q_reg;
    assign cnt_idx = (item_reg.operation == arr_pkg::OP_CREATE_HEAP) ? free_reg : h_reg;
    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT;
    assign m_data = '{status: status_reg, found_kind: fkind_reg,
                      found_key: fkey_reg, offset: off_reg};

    always_comb begin
        clr_en = 1'b0;
        if (state_reg == S_SCAN) begin
            case (item_reg.operation)
                arr_pkg::OP_CREATE_BUF:
                    clr_en = is_plain && (e.key == item_reg.key || ovl);
                arr_pkg::OP_CREATE_PLACED:
                    clr_en = pass_reg == P_B && is_placed && e.key == item_reg.key && !hit_reg;
                arr_pkg::OP_DESTROY:
                    clr_en = (pass_reg == P_A && is_plain && e.key == item_reg.key && !hit_reg)
                        || (pass_reg == P_B && is_placed && e.key == item_reg.key && !hit_reg)
                        || (pass_reg == P_C && is_heap && e.key == item_reg.key && !hit_reg)
                        || (pass_reg == P_D && is_placed && e.owner == item_reg.key);
                default: clr_en = 1'b0;
            endcase
        end
    end

    always_comb begin
        // The placed-buffer write waits until the layer search has stopped stepping.
        wr_en = state_reg == S_WRITE
            && !(item_reg.operation == arr_pkg::OP_CREATE_PLACED && vld_q_reg);
        wr_idx = free_reg;
        wr_entry.kind = arr_pkg::KIND_PLAIN;
        wr_entry.key = item_reg.key;
        wr_entry.start = item_reg.address;
        wr_entry.stop = end_reg;
        wr_entry.owner = '0;
        wr_entry.layer = '0;
        wr_entry.rt = 1'b0;
        cnt_wr_en = 1'b0;
        cnt_wdata = '0;
        case (item_reg.operation)
            arr_pkg::OP_CREATE_PLACED: begin
                wr_entry.kind = arr_pkg::KIND_PLACED;
                wr_entry.owner = item_reg.heap_key;
                wr_entry.layer = layer_reg;
                wr_entry.rt = item_reg.raytracing;
                cnt_wr_en = wr_en && layer_reg == count_reg
                    && count_reg < CW'(arr_pkg::TABLE_ENTRIES);
                cnt_wdata = count_reg + CW'(1);
            end
            arr_pkg::OP_CREATE_HEAP: begin
                wr_entry.kind = arr_pkg::KIND_HEAP;
                wr_entry.key = item_reg.heap_key;
                wr_idx = free_reg;
                cnt_wr_en = wr_en;
                cnt_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass_reg <= P_A;
            ptr_reg <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        end_reg <= sum[64] ? '1 : sum[63:0];
                        ptr_reg <= '0;
                        vld_q_reg <= 1'b0;
                        pass_reg <= P_A;
                        free_ok_reg <= 1'b0;
                        h_ok_reg <= 1'b0;
                        r_ok_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        used_reg <= '0;
                        status_reg <= (s_data.operation == arr_pkg::OP_LOOKUP)
                            ? arr_pkg::ST_NOT_FOUND : arr_pkg::ST_IGNORED;
                        fkind_reg <= arr_pkg::FOUND_NONE;
                        fkey_reg <= '0;
                        off_reg <= '0;
                        case (s_data.operation)
                            arr_pkg::OP_CREATE_BUF:
                                state_reg <= s_data.is_buffer ? S_SCAN : S_OUT;
                            arr_pkg::OP_CREATE_PLACED:
                                state_reg <= (s_data.is_buffer && !s_data.heap_denies_buffers)
                                    ? S_SCAN : S_OUT;
                            arr_pkg::OP_CREATE_HEAP:
                                state_reg <= (!s_data.heap_denies_buffers && s_data.address != '0)
                                    ? S_SCAN : S_OUT;
                            arr_pkg::OP_LOOKUP:
                                state_reg <= s_data.address != '0 ? S_SCAN : S_OUT;
                            arr_pkg::OP_DESTROY: state_reg <= S_SCAN;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (ptr_reg != LAST) begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    vld_q_reg <= ptr_reg != LAST;
                    idx_q_reg <= ptr_reg[IW-1:0];
                    if (vld_q_reg) begin
                        // Free slot search runs in every pass; only the final pass of a create is used.
                        if (!ev && !free_ok_reg) begin
                            free_ok_reg <= 1'b1;
                            free_reg <= idx_q_reg;
                        end
                        case (item_reg.operation)
                            arr_pkg::OP_CREATE_BUF: begin
                                if (clr_en) begin
                                    if (!free_ok_reg) begin
                                        free_ok_reg <= 1'b1;
                                        free_reg <= idx_q_reg;
                                    end
                                end
                            end
                            arr_pkg::OP_CREATE_PLACED: begin
                                if (pass_reg == P_A) begin
                                    if (is_heap && e.key == item_reg.heap_key && !h_ok_reg) begin
                                        h_ok_reg <= 1'b1;
                                        h_reg <= idx_q_reg;
                                    end
                                end else if (pass_reg == P_B) begin
                                    if (clr_en) begin
                                        hit_reg <= 1'b1;
                                        if (!free_ok_reg) begin
                                            free_ok_reg <= 1'b1;
                                            free_reg <= idx_q_reg;
                                        end
                                    end else if (is_placed && e.owner == item_reg.heap_key
                                                 && ovl && {1'b0, e.layer} <= (CW + 1)'(
                                                 arr_pkg::TABLE_ENTRIES)) begin
                                        used_reg[e.layer] <= 1'b1;
                                    end
                                end
                            end
                            arr_pkg::OP_CREATE_HEAP: begin
                                if ((is_heap && e.key == item_reg.heap_key)
                                    || ((is_plain || is_heap) && ovl)) begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            arr_pkg::OP_LOOKUP: begin
                                if (pass_reg == P_A) begin
                                    if (is_plain && cov && !r_ok_reg) begin
                                        r_ok_reg <= 1'b1;
                                        rkey_reg <= e.key;
                                        rstart_reg <= e.start;
                                    end
                                    if (is_heap && cov && !h_ok_reg) begin
                                        h_ok_reg <= 1'b1;
                                        hkey_reg <= e.key;
                                        hstart_reg <= e.start;
                                    end
                                end else if (is_placed && e.owner == hkey_reg && cov) begin
                                    if (pass_reg == P_B) begin
                                        if (!r_ok_reg || e.layer < rlayer_reg) begin
                                            r_ok_reg <= 1'b1;
                                            r_reg <= idx_q_reg;
                                            rlayer_reg <= e.layer;
                                            rend_reg <= e.stop;
                                            rrt_reg <= e.rt;
                                            rkey_reg <= e.key;
                                            rstart_reg <= e.start;
                                        end
                                    end else if (idx_q_reg != r_reg
                                                 && e.rt == item_reg.raytracing
                                                 && (e.stop > rend_reg
                                                     || rrt_reg != item_reg.raytracing)) begin
                                        rend_reg <= e.stop;
                                        rrt_reg <= e.rt;
                                        rkey_reg <= e.key;
                                        rstart_reg <= e.start;
                                    end
                                end
                            end
                            arr_pkg::OP_DESTROY: begin
                                if (clr_en && pass_reg != P_D) begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (scan_done) begin
                        ptr_reg <= '0;
                        case (item_reg.operation)
                            arr_pkg::OP_CREATE_BUF: begin
                                status_reg <= arr_pkg::ST_ERROR;
                                state_reg <= free_ok_reg ? S_WRITE : S_OUT;
                            end
                            arr_pkg::OP_CREATE_PLACED: begin
                                if (pass_reg == P_A) begin
                                    status_reg <= arr_pkg::ST_ERROR;
                                    free_ok_reg <= 1'b0;
                                    pass_reg <= P_B;
                                    if (!h_ok_reg) begin
                                        state_reg <= S_OUT;
                                    end
                                end else begin
                                    state_reg <= free_ok_reg ? S_CNT : S_OUT;
                                end
                            end
                            arr_pkg::OP_CREATE_HEAP: begin
                                status_reg <= arr_pkg::ST_ERROR;
                                state_reg <= (free_ok_reg && !hit_reg) ? S_WRITE : S_OUT;
                            end
                            arr_pkg::OP_LOOKUP: begin
                                if (pass_reg == P_A) begin
                                    if (r_ok_reg) begin
                                        state_reg <= S_OUT;
                                        status_reg <= arr_pkg::ST_DONE;
                                        fkind_reg <= arr_pkg::FOUND_BUFFER;
                                        fkey_reg <= rkey_reg;
                                        off_reg <= item_reg.address - rstart_reg;
                                    end else if (!h_ok_reg) begin
                                        state_reg <= S_OUT;
                                    end else begin
                                        pass_reg <= P_B;
                                    end
                                end else if (pass_reg == P_B && r_ok_reg) begin
                                    pass_reg <= P_C;
                                end else begin
                                    state_reg <= S_OUT;
                                    status_reg <= arr_pkg::ST_DONE;
                                    fkind_reg <= r_ok_reg ? arr_pkg::FOUND_BUFFER
                                                          : arr_pkg::FOUND_HEAP;
                                    fkey_reg <= r_ok_reg ? rkey_reg : hkey_reg;
                                    off_reg <= item_reg.address
                                        - (r_ok_reg ? rstart_reg : hstart_reg);
                                end
                            end
                            arr_pkg::OP_DESTROY: begin
                                status_reg <= arr_pkg::ST_DONE;
                                if (pass_reg == P_C && hit_reg) begin
                                    pass_reg <= P_D;
                                end else if (hit_reg || pass_reg == P_D) begin
                                    state_reg <= S_OUT;
                                end else if (pass_reg == P_C) begin
                                    status_reg <= arr_pkg::ST_NOT_FOUND;
                                    state_reg <= S_OUT;
                                end else begin
                                    pass_reg <= pass_reg == P_A ? P_B : P_C;
                                end
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_CNT: begin
                    // cnt_rdata is valid here: its address has held since the heap scan.
                    count_reg <= (cnt_rdata > CW'(arr_pkg::TABLE_ENTRIES))
                        ? CW'(arr_pkg::TABLE_ENTRIES) : cnt_rdata;
                    layer_reg <= '0;
                    ptr_reg <= '0;
                    state_reg <= S_WRITE;
                    vld_q_reg <= 1'b1;
                end
                S_WRITE: begin
                    if (item_reg.operation == arr_pkg::OP_CREATE_PLACED && vld_q_reg) begin
                        // One layer tested per cycle; the write fires once the search has stopped.
                        state_reg <= S_WRITE;
                        if (layer_reg < count_reg && used_reg[layer_reg]) begin
                            layer_reg <= layer_reg + CW'(1);
                        end else begin
                            vld_q_reg <= 1'b0;
                        end
                    end else begin
                        status_reg <= arr_pkg::ST_DONE;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- verif/tb_address_range_object_resolver_core.sv -----
// Testbench for address_range_object_resolver_core: directed and random table operations
// checked against a table model held in the testbench. Depends on arr_pkg and the RTL.
module tb_address_range_object_resolver_core;

    localparam int N = arr_pkg::TABLE_ENTRIES;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    arr_pkg::arr_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    arr_pkg::arr_out_t m_data;

    address_range_object_resolver_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    bit          tv [N];
    logic [1:0]  tkind [N];
    logic [31:0] tkey [N];
    logic [63:0] tstart [N];
    logic [63:0] tend [N];
    logic [31:0] towner [N];
    int          tlayer [N];
    logic        trt [N];
    int          hlayers [N];

    arr_pkg::arr_out_t pending_results[$];
    int                mismatches = 0;
    bit                hold_sink = 1'b0;

    function automatic bit is_live(int i, logic [1:0] k);
        return tv[i] && tkind[i] == k;
    endfunction

    function automatic int find_entry(logic [1:0] k, logic [31:0] key);
        for (int i = 0; i < N; i++)
            if (is_live(i, k) && tkey[i] == key) return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < N; i++)
            if (!tv[i]) return i;
        return -1;
    endfunction

    function automatic bit hits(int i, logic [63:0] s, logic [63:0] e);
        return tend[i] > s && tstart[i] < e;
    endfunction

    function automatic bit holds(int i, logic [63:0] a);
        return a >= tstart[i] && a < tend[i];
    endfunction

    function automatic void place(int f, logic [1:0] k, logic [31:0] key,
                                  logic [63:0] s, logic [63:0] e);
        tv[f] = 1'b1; tkind[f] = k; tkey[f] = key; tstart[f] = s; tend[f] = e;
        towner[f] = '0; tlayer[f] = 0; trt[f] = 1'b0;
    endfunction

    function automatic arr_pkg::arr_out_t resolve(arr_pkg::arr_in_t d);
        arr_pkg::arr_out_t o;
        logic [63:0]       e;
        int                f, h, r, sel, layer, cnt;
        bit                used [N+1];
        bit                clash;
        o = '0;
        o.status = arr_pkg::ST_IGNORED;
        e = d.address + d.size;
        if (e < d.address) e = '1;
        case (d.operation)
            arr_pkg::OP_CREATE_BUF: if (d.is_buffer) begin
                for (int i = 0; i < N; i++)
                    if (is_live(i, arr_pkg::KIND_PLAIN) &&
                        (tkey[i] == d.key || hits(i, d.address, e)))
                        tv[i] = 1'b0;
                f = free_slot();
                if (f < 0) o.status = arr_pkg::ST_ERROR;
                else begin
                    place(f, arr_pkg::KIND_PLAIN, d.key, d.address, e);
                    o.status = arr_pkg::ST_DONE;
                end
            end
            arr_pkg::OP_CREATE_PLACED: if (!d.heap_denies_buffers && d.is_buffer) begin
                h = find_entry(arr_pkg::KIND_HEAP, d.heap_key);
                if (h < 0) o.status = arr_pkg::ST_ERROR;
                else begin
                    r = find_entry(arr_pkg::KIND_PLACED, d.key);
                    if (r >= 0) tv[r] = 1'b0;
                    f = free_slot();
                    if (f < 0) o.status = arr_pkg::ST_ERROR;
                    else begin
                        foreach (used[i]) used[i] = 1'b0;
                        for (int i = 0; i < N; i++)
                            if (is_live(i, arr_pkg::KIND_PLACED) && towner[i] == d.heap_key &&
                                hits(i, d.address, e) && tlayer[i] <= N)
                                used[tlayer[i]] = 1'b1;
                        cnt = hlayers[h] > N ? N : hlayers[h];
                        for (layer = 0; layer < cnt; layer++)
                            if (!used[layer]) break;
                        if (layer == cnt && cnt < N) hlayers[h] = cnt + 1;
                        place(f, arr_pkg::KIND_PLACED, d.key, d.address, e);
                        towner[f] = d.heap_key;
                        tlayer[f] = layer;
                        trt[f] = d.raytracing;
                        o.status = arr_pkg::ST_DONE;
                    end
                end
            end
            arr_pkg::OP_CREATE_HEAP: if (!d.heap_denies_buffers && d.address != 0) begin
                o.status = arr_pkg::ST_ERROR;
                if (find_entry(arr_pkg::KIND_HEAP, d.heap_key) < 0) begin
                    clash = 1'b0;
                    for (int i = 0; i < N; i++)
                        if ((is_live(i, arr_pkg::KIND_PLAIN) ||
                             is_live(i, arr_pkg::KIND_HEAP)) &&
                            hits(i, d.address, e))
                            clash = 1'b1;
                    f = free_slot();
                    if (!clash && f >= 0) begin
                        place(f, arr_pkg::KIND_HEAP, d.heap_key, d.address, e);
                        hlayers[f] = 0;
                        o.status = arr_pkg::ST_DONE;
                    end
                end
            end
            arr_pkg::OP_LOOKUP: begin
                o.status = arr_pkg::ST_NOT_FOUND;
                r = -1;
                h = -1;
                if (d.address != 0) begin
                    for (int i = 0; i < N && r < 0; i++)
                        if (is_live(i, arr_pkg::KIND_PLAIN) && holds(i, d.address)) r = i;
                    if (r < 0) begin
                        for (int i = 0; i < N && h < 0; i++)
                            if (is_live(i, arr_pkg::KIND_HEAP) && holds(i, d.address)) h = i;
                        if (h >= 0) begin
                            for (int i = 0; i < N; i++)
                                if (is_live(i, arr_pkg::KIND_PLACED) && towner[i] == tkey[h] &&
                                    holds(i, d.address) && (r < 0 || tlayer[i] < tlayer[r]))
                                    r = i;
                            if (r >= 0) begin
                                sel = r;
                                for (int i = 0; i < N; i++)
                                    if (i != r && is_live(i, arr_pkg::KIND_PLACED) &&
                                        towner[i] == tkey[h] && holds(i, d.address) &&
                                        trt[i] == d.raytracing &&
                                        (tend[i] > tend[sel] || trt[sel] != d.raytracing))
                                        sel = i;
                                r = sel;
                            end
                        end
                    end
                    if (r >= 0) begin
                        o = '{arr_pkg::ST_DONE, arr_pkg::FOUND_BUFFER, tkey[r],
                              d.address - tstart[r]};
                    end else if (h >= 0) begin
                        o = '{arr_pkg::ST_DONE, arr_pkg::FOUND_HEAP, tkey[h],
                              d.address - tstart[h]};
                    end
                end
            end
            arr_pkg::OP_DESTROY: begin
                o.status = arr_pkg::ST_DONE;
                r = find_entry(arr_pkg::KIND_PLAIN, d.key);
                if (r < 0) r = find_entry(arr_pkg::KIND_PLACED, d.key);
                if (r >= 0) tv[r] = 1'b0;
                else begin
                    h = find_entry(arr_pkg::KIND_HEAP, d.key);
                    if (h < 0) o.status = arr_pkg::ST_NOT_FOUND;
                    else begin
                        tv[h] = 1'b0;
                        for (int i = 0; i < N; i++)
                            if (is_live(i, arr_pkg::KIND_PLACED) && towner[i] == d.key)
                                tv[i] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(arr_pkg::arr_in_t d);
        repeat (gap_len() + 1) @(negedge aclk);
        s_data <= d;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results = {pending_results, resolve(d)};
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (hold_sink) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                        ($urandom_range(0, 9) == 0 ? 1'b0 : ($urandom_range(0, 1) == 1));
    end

    always @(posedge aclk) begin
        arr_pkg::arr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, m_data);
                end
            end
        end
    end

    function automatic arr_pkg::arr_in_t mk(logic [2:0] op, logic [31:0] key, logic [31:0] hk,
                                            logic [63:0] addr, logic [63:0] sz,
                                            logic b, logic deny, logic rt);
        arr_pkg::arr_in_t d;
        d = '{op, key, hk, addr, sz, b, deny, rt};
        return d;
    endfunction

    task automatic drain();
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed();
        send_item(mk(arr_pkg::OP_LOOKUP, 0, 0, 0, 0, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_BUF, 1, 0, 64'h1000, 64'h100, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_BUF, 2, 0, 64'h1080, 64'h100, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_BUF, 3, 0, 64'h0, 64'h10, 0, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_BUF, 2, 0, 64'h0, 64'h10, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_HEAP, 0, 10, 64'h0, 64'h100, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_HEAP, 0, 10, 64'h8, 64'h100, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_HEAP, 0, 10, 64'h20000, 64'h1000, 1, 1, 0));
        send_item(mk(arr_pkg::OP_CREATE_HEAP, 0, 10, 64'h20000, 64'h1000, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_HEAP, 0, 10, 64'h40000, 64'h1000, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_HEAP, 0, 11, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF,
                     1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_PLACED, 20, 10, 64'h20000, 64'h200, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_PLACED, 21, 10, 64'h20100, 64'h400, 1, 0, 1));
        send_item(mk(arr_pkg::OP_CREATE_PLACED, 22, 10, 64'h20000, 64'h800, 1, 0, 1));
        send_item(mk(arr_pkg::OP_CREATE_PLACED, 23, 99, 64'h20000, 64'h10, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_PLACED, 20, 10, 64'h20000, 64'h300, 1, 0, 0));
        send_item(mk(arr_pkg::OP_LOOKUP, 0, 0, 64'h20150, 0, 1, 0, 1));
        send_item(mk(arr_pkg::OP_LOOKUP, 0, 0, 64'h20150, 0, 1, 0, 0));
        send_item(mk(arr_pkg::OP_LOOKUP, 0, 0, 64'h20F00, 0, 1, 0, 0));
        send_item(mk(arr_pkg::OP_LOOKUP, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE, 0, 1, 0, 0));
        send_item(mk(3'd5, '1, '1, '1, '1, 1, 1, 1));
        send_item(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(arr_pkg::OP_DESTROY, 1, 0, 0, 0, 1, 0, 0));
        send_item(mk(arr_pkg::OP_DESTROY, 10, 0, 0, 0, 1, 0, 0));
        send_item(mk(arr_pkg::OP_DESTROY, 12345, 0, 0, 0, 1, 0, 0));
    endtask

    task automatic test_table_full();
        for (int i = 0; i < N + 3; i++)
            send_item(mk(arr_pkg::OP_CREATE_BUF, 100 + i, 0, 64'h100000 + i * 64'h100,
                         64'h80, 1, 0, 0));
        send_item(mk(arr_pkg::OP_CREATE_HEAP, 0, 500, 64'h900000, 64'h100, 1, 0, 0));
        send_item(mk(arr_pkg::OP_LOOKUP, 0, 0, 64'h100510, 0, 1, 0, 0));
        for (int i = 0; i < N + 3; i++)
            send_item(mk(arr_pkg::OP_DESTROY, 100 + i, 0, 0, 0, 1, 0, 0));
    endtask

    function automatic logic [31:0] rnd_key();
        return ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 15);
    endfunction

    function automatic logic [63:0] rnd_addr();
        case ($urandom_range(0, 9))
            0: return {$urandom(), $urandom()};
            1: return 64'h0;
            2: return 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(0, 4095));
            default: return 64'h10000 + 64'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [63:0] rnd_size();
        case ($urandom_range(0, 9))
            0: return {$urandom(), $urandom()};
            1: return 64'h0;
            default: return 64'($urandom_range(1, 16'h2000));
        endcase
    endfunction

    task automatic test_random(int count);
        arr_pkg::arr_in_t d;
        for (int n = 0; n < count; n++) begin
            d.operation = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(5, 7))
                                                        : 3'($urandom_range(0, 4));
            d.key = rnd_key();
            d.heap_key = rnd_key();
            d.address = rnd_addr();
            d.size = rnd_size();
            d.is_buffer = $urandom_range(0, 9) != 0;
            d.heap_denies_buffers = $urandom_range(0, 9) == 0;
            d.raytracing = 1'($urandom_range(0, 1));
            if (d.operation == arr_pkg::OP_DESTROY && $urandom_range(0, 3) == 0)
                d.key = d.heap_key;
            send_item(d);
            if (n == count / 2) begin
                hold_sink = 1'b1;
                drain();
                hold_sink = 1'b0;
            end
        end
    endtask

    initial begin
        foreach (tv[i]) tv[i] = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_table_full();
        test_random(1300);
        drain();
        repeat (400) @(negedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
